// File: rtl/core/gmst_pkg.sv
// Shared types, codes and arithmetic helpers for the G-code motion step tracker.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package gmst_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned FeedW = 32;
  localparam int unsigned ExtrW = 31;
  localparam int unsigned FuncW = 2;
  localparam int unsigned CfgIdxW = 2;

  // Command codes carried in the func field.
  localparam logic [FuncW-1:0] FUNC_RAPID  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_LINEAR = 2'd1;
  localparam logic [FuncW-1:0] FUNC_HOME   = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ABS_POSITIONING = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ABS_EXTRUSION   = 2'd1;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic                   has_x;
    logic                   has_y;
    logic                   has_z;
    logic                   has_e;
    logic                   has_f;
    logic signed [PosW-1:0] x_word;
    logic signed [PosW-1:0] y_word;
    logic signed [PosW-1:0] z_word;
    logic signed [PosW-1:0] e_word;
    logic [FeedW-1:0]       f_word;
  } cmd_t;

  typedef struct packed {
    logic signed [PosW-1:0] start_x;
    logic signed [PosW-1:0] start_y;
    logic signed [PosW-1:0] start_z;
    logic signed [PosW-1:0] end_x;
    logic signed [PosW-1:0] end_y;
    logic signed [PosW-1:0] end_z;
    logic [ExtrW-1:0]       extrusion_amount;
    logic [FeedW-1:0]       speed;
    logic                   extruding;
    logic                   step_kind;
  } seg_t;

  typedef struct packed {
    logic abs_positioning;
    logic abs_extrusion;
  } mode_t;

  // Signed add that clamps to the 32-bit range.
  function automatic logic signed [PosW-1:0] sat_add(input logic signed [PosW-1:0] a,
                                                     input logic signed [PosW-1:0] b);
    logic signed [PosW:0] s;
    logic signed [PosW-1:0] r;
    s = {a[PosW-1], a} + {b[PosW-1], b};
    if (s[PosW] != s[PosW-1]) begin
      r = s[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    end else begin
      r = s[PosW-1:0];
    end
    return r;
  endfunction

  // New coordinate for one axis word under the given mode.
  function automatic logic signed [PosW-1:0] new_coord(input logic has,
                                                       input logic signed [PosW-1:0] cur,
                                                       input logic signed [PosW-1:0] word,
                                                       input logic absolute);
    logic signed [PosW-1:0] r;
    if (!has) begin
      r = cur;
    end else if (absolute) begin
      r = word;
    end else begin
      r = sat_add(cur, word);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/gmst_in_reg.sv
// Input register stage: captures one command per transfer and holds it for the execute stage.
// Depends on gmst_pkg for the command type.
module gmst_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gmst_pkg::cmd_t    cmd_in,
  output logic              cmd_valid,
  output gmst_pkg::cmd_t    cmd,
  input  logic              take
);

  logic           valid;
  gmst_pkg::cmd_t cmd_r;

  // The stage refills in the same cycle that the execute stage consumes it.
  assign in_ready  = !valid || take;
  assign cmd_valid = valid;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_in;
    end
  end

endmodule

// File: rtl/core/gmst_exec.sv
// Execute stage: holds the tracked positions and forms one segment per command.
// Depends on gmst_pkg for types, command codes and saturating arithmetic.
module gmst_exec (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  gmst_pkg::cmd_t   cmd,
  input  gmst_pkg::mode_t  mode,
  output gmst_pkg::seg_t   seg
);

  logic signed [gmst_pkg::PosW-1:0] position_x, position_y, position_z;
  logic signed [gmst_pkg::PosW-1:0] extruder_position, previous_extruder;
  logic signed [gmst_pkg::PosW-1:0] position_x_next, position_y_next, position_z_next;
  logic signed [gmst_pkg::PosW-1:0] extruder_position_next, previous_extruder_next;

  logic                             is_home;
  logic                             is_linear;
  logic                             home_all;
  logic signed [gmst_pkg::PosW-1:0] move_e;
  logic signed [gmst_pkg::PosW:0]   e_diff;
  logic                             e_advance;

  assign is_home   = (cmd.func == gmst_pkg::FUNC_HOME);
  assign is_linear = (cmd.func == gmst_pkg::FUNC_LINEAR);
  assign home_all  = !cmd.has_x && !cmd.has_y && !cmd.has_z;

  assign move_e = gmst_pkg::new_coord(cmd.has_e, extruder_position, cmd.e_word,
                                      mode.abs_extrusion);
  assign e_diff = {move_e[gmst_pkg::PosW-1], move_e}
                - {previous_extruder[gmst_pkg::PosW-1], previous_extruder};
  assign e_advance = !e_diff[gmst_pkg::PosW] && (e_diff != '0);

  always_comb begin
    if (is_home) begin
      position_x_next        = (home_all || cmd.has_x) ? '0 : position_x;
      position_y_next        = (home_all || cmd.has_y) ? '0 : position_y;
      position_z_next        = (home_all || cmd.has_z) ? '0 : position_z;
      extruder_position_next = extruder_position;
      previous_extruder_next = extruder_position;
    end else begin
      position_x_next = gmst_pkg::new_coord(cmd.has_x, position_x, cmd.x_word,
                                            mode.abs_positioning);
      position_y_next = gmst_pkg::new_coord(cmd.has_y, position_y, cmd.y_word,
                                            mode.abs_positioning);
      position_z_next = gmst_pkg::new_coord(cmd.has_z, position_z, cmd.z_word,
                                            mode.abs_positioning);
      extruder_position_next = move_e;
      previous_extruder_next = move_e;
    end
  end

  always_comb begin
    seg.start_x = position_x;
    seg.start_y = position_y;
    seg.start_z = position_z;
    seg.end_x   = position_x_next;
    seg.end_y   = position_y_next;
    seg.end_z   = position_z_next;
    seg.extrusion_amount = '0;
    seg.extruding        = 1'b0;
    seg.speed            = '0;
    seg.step_kind        = 1'b0;
    if (!is_home) begin
      // An advance of 2^31 or more clamps to the largest 31-bit value.
      if (is_linear && e_advance) begin
        seg.extrusion_amount = e_diff[gmst_pkg::PosW-1] ? {gmst_pkg::ExtrW{1'b1}}
                                                         : e_diff[gmst_pkg::ExtrW-1:0];
        seg.extruding = 1'b1;
      end
      seg.speed     = cmd.has_f ? cmd.f_word : '0;
      seg.step_kind = is_linear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_x        <= '0;
      position_y        <= '0;
      position_z        <= '0;
      extruder_position <= '0;
      previous_extruder <= '0;
    end else if (fire) begin
      position_x        <= position_x_next;
      position_y        <= position_y_next;
      position_z        <= position_z_next;
      extruder_position <= extruder_position_next;
      previous_extruder <= previous_extruder_next;
    end
  end

endmodule

// File: rtl/core/gmst_out_reg.sv
// Result register: holds one finished segment until the downstream side takes it.
// Depends on gmst_pkg for the segment type.
module gmst_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  gmst_pkg::seg_t  seg_in,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output gmst_pkg::seg_t  seg
);

  logic           valid;
  gmst_pkg::seg_t seg_r;

  // A new segment may enter while the held one leaves in the same cycle.
  assign can_load  = !valid || out_ready;
  assign out_valid = valid;
  assign seg       = seg_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      seg_r <= seg_in;
    end
  end

endmodule

// File: rtl/core/gcode_motion_step_tracker.sv
// Tracks X, Y, Z and extruder positions over decoded G0, G1 and G28 commands and emits one
// move segment per command. A command passes an input register, the execute stage and a
// result register. The segment is formed combinationally in the execute stage and is loaded
// into the result register, which presents it, once that register has room. One command is
// taken every cycle as long as the result side keeps up. A stalled result holds the input
// side through the execute stage. Mode registers are written through the configuration
// channel, which is always ready; writes to indexes other than 0 and 1 are ignored.
module gcode_motion_step_tracker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gmst_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic                                  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [gmst_pkg::FuncW-1:0]            func,
  input  logic                                  has_x,
  input  logic                                  has_y,
  input  logic                                  has_z,
  input  logic                                  has_e,
  input  logic                                  has_f,
  input  logic signed [gmst_pkg::PosW-1:0]      x_word,
  input  logic signed [gmst_pkg::PosW-1:0]      y_word,
  input  logic signed [gmst_pkg::PosW-1:0]      z_word,
  input  logic signed [gmst_pkg::PosW-1:0]      e_word,
  input  logic [gmst_pkg::FeedW-1:0]            f_word,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [gmst_pkg::PosW-1:0]      start_x,
  output logic signed [gmst_pkg::PosW-1:0]      start_y,
  output logic signed [gmst_pkg::PosW-1:0]      start_z,
  output logic signed [gmst_pkg::PosW-1:0]      end_x,
  output logic signed [gmst_pkg::PosW-1:0]      end_y,
  output logic signed [gmst_pkg::PosW-1:0]      end_z,
  output logic [gmst_pkg::ExtrW-1:0]            extrusion_amount,
  output logic [gmst_pkg::FeedW-1:0]            speed,
  output logic                                  extruding,
  output logic                                  step_kind
);

  gmst_pkg::mode_t mode;
  gmst_pkg::cmd_t  cmd_in;
  gmst_pkg::cmd_t  cmd;
  gmst_pkg::seg_t  seg_calc;
  gmst_pkg::seg_t  seg;
  logic            cmd_valid;
  logic            can_load;
  logic            fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode.abs_positioning <= 1'b1;
      mode.abs_extrusion   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        gmst_pkg::CFG_ABS_POSITIONING: mode.abs_positioning <= cfg_data;
        gmst_pkg::CFG_ABS_EXTRUSION:   mode.abs_extrusion   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd_in.func   = func;
    cmd_in.has_x  = has_x;
    cmd_in.has_y  = has_y;
    cmd_in.has_z  = has_z;
    cmd_in.has_e  = has_e;
    cmd_in.has_f  = has_f;
    cmd_in.x_word = x_word;
    cmd_in.y_word = y_word;
    cmd_in.z_word = z_word;
    cmd_in.e_word = e_word;
    cmd_in.f_word = f_word;
  end

  // A command executes when one is held and the result register has room.
  assign fire = cmd_valid && can_load;

  gmst_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_in    (cmd_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (fire)
  );

  gmst_exec u_exec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cmd  (cmd),
    .mode (mode),
    .seg  (seg_calc)
  );

  gmst_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd_valid),
    .seg_in    (seg_calc),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .seg       (seg)
  );

  assign start_x          = seg.start_x;
  assign start_y          = seg.start_y;
  assign start_z          = seg.start_z;
  assign end_x            = seg.end_x;
  assign end_y            = seg.end_y;
  assign end_z            = seg.end_z;
  assign extrusion_amount = seg.extrusion_amount;
  assign speed            = seg.speed;
  assign extruding        = seg.extruding;
  assign step_kind        = seg.step_kind;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for gcode_motion_step_tracker: directed command table, then random
// command streams under every positioning and extrusion mode, with random gaps and stalls in all but the first.
// Depends on gmst_pkg (rtl/core/gmst_pkg.sv) and the tracker RTL.
module testbench;

  localparam logic [gmst_pkg::FuncW-1:0]     FUNC_SPARE   = 2'd3;
  localparam logic [gmst_pkg::CfgIdxW-1:0]   CFG_UNUSED_A = 2'd2;
  localparam logic [gmst_pkg::CfgIdxW-1:0]   CFG_UNUSED_B = 2'd3;
  localparam logic signed [gmst_pkg::PosW-1:0] POS_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [gmst_pkg::PosW-1:0] POS_MIN    = 32'sh8000_0000;
  localparam logic signed [gmst_pkg::PosW-1:0] MM         = 32'sh0001_0000;
  localparam logic [gmst_pkg::ExtrW-1:0]     EXTR_SAT     = '1;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                      kind;
    gmst_pkg::cmd_t                 cmd;
    bit                             typed;
    gmst_pkg::seg_t                 seg;
    logic [gmst_pkg::CfgIdxW-1:0]   index;
    logic                           data;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready, cfg_data;
  logic [gmst_pkg::CfgIdxW-1:0] cfg_index;
  logic in_valid, in_ready;
  logic [gmst_pkg::FuncW-1:0] func;
  logic has_x, has_y, has_z, has_e, has_f;
  logic signed [gmst_pkg::PosW-1:0] x_word, y_word, z_word, e_word;
  logic [gmst_pkg::FeedW-1:0] f_word;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [gmst_pkg::PosW-1:0] start_x, start_y, start_z, end_x, end_y, end_z;
  logic [gmst_pkg::ExtrW-1:0] extrusion_amount;
  logic [gmst_pkg::FeedW-1:0] speed;
  logic extruding, step_kind;

  // Tracker state as the bench expects it to be.
  logic signed [gmst_pkg::PosW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [gmst_pkg::PosW-1:0] ext_pos = '0, ext_prev = '0;
  logic abs_pos_mode = 1'b1, abs_ext_mode = 1'b1;

  gmst_pkg::seg_t pending_segments[$];
  row_t script[$];
  int   fault_count = 0;
  bit   gaps_on = 1'b1, stalls_on = 1'b1;

  always #6 clk = ~clk;

  gcode_motion_step_tracker i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .has_x(has_x), .has_y(has_y), .has_z(has_z), .has_e(has_e), .has_f(has_f),
    .x_word(x_word), .y_word(y_word), .z_word(z_word), .e_word(e_word), .f_word(f_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .extrusion_amount(extrusion_amount), .speed(speed),
    .extruding(extruding), .step_kind(step_kind)
  );

  function automatic logic signed [gmst_pkg::PosW-1:0] axis_target(
      input logic has,
      input logic signed [gmst_pkg::PosW-1:0] cur,
      input logic signed [gmst_pkg::PosW-1:0] word,
      input logic absolute);
    longint total;
    if (!has) return cur;
    if (absolute) return word;
    total = longint'(cur) + longint'(word);
    if (total > longint'(POS_MAX)) return POS_MAX;
    if (total < longint'(POS_MIN)) return POS_MIN;
    return total[gmst_pkg::PosW-1:0];
  endfunction

  // Applies one command to the tracked state and returns the segment it should produce.
  function automatic gmst_pkg::seg_t track_command(input gmst_pkg::cmd_t c);
    gmst_pkg::seg_t s;
    logic signed [gmst_pkg::PosW-1:0] nx, ny, nz, ne;
    longint gain;
    bit clear_all;
    s = '0;
    s.start_x = pos_x;
    s.start_y = pos_y;
    s.start_z = pos_z;
    if (c.func == gmst_pkg::FUNC_HOME) begin
      clear_all = !(c.has_x || c.has_y || c.has_z);
      nx = (clear_all || c.has_x) ? '0 : pos_x;
      ny = (clear_all || c.has_y) ? '0 : pos_y;
      nz = (clear_all || c.has_z) ? '0 : pos_z;
      ext_prev = ext_pos;
    end else begin
      nx = axis_target(c.has_x, pos_x, c.x_word, abs_pos_mode);
      ny = axis_target(c.has_y, pos_y, c.y_word, abs_pos_mode);
      nz = axis_target(c.has_z, pos_z, c.z_word, abs_pos_mode);
      ne = axis_target(c.has_e, ext_pos, c.e_word, abs_ext_mode);
      gain = longint'(ne) - longint'(ext_prev);
      if (c.func == gmst_pkg::FUNC_LINEAR && gain > 0) begin
        s.extrusion_amount = (gain > longint'(EXTR_SAT)) ? EXTR_SAT
                                                         : gain[gmst_pkg::ExtrW-1:0];
        s.extruding = 1'b1;
      end
      s.speed = c.has_f ? c.f_word : '0;
      s.step_kind = (c.func == gmst_pkg::FUNC_LINEAR);
      ext_pos = ne;
      ext_prev = ne;
    end
    pos_x = nx;
    pos_y = ny;
    pos_z = nz;
    s.end_x = nx;
    s.end_y = ny;
    s.end_z = nz;
    return s;
  endfunction

  function automatic gmst_pkg::cmd_t mk_cmd(input logic [gmst_pkg::FuncW-1:0] f,
                                            input logic [4:0] flags,
                                            input logic signed [gmst_pkg::PosW-1:0] x,
                                            input logic signed [gmst_pkg::PosW-1:0] y,
                                            input logic signed [gmst_pkg::PosW-1:0] z,
                                            input logic signed [gmst_pkg::PosW-1:0] e,
                                            input logic [gmst_pkg::FeedW-1:0] feed);
    gmst_pkg::cmd_t c;
    c.func = f;
    {c.has_x, c.has_y, c.has_z, c.has_e, c.has_f} = flags;
    c.x_word = x;
    c.y_word = y;
    c.z_word = z;
    c.e_word = e;
    c.f_word = feed;
    return c;
  endfunction

  function automatic gmst_pkg::seg_t mk_seg(input logic signed [gmst_pkg::PosW-1:0] sx,
                                            input logic signed [gmst_pkg::PosW-1:0] sy,
                                            input logic signed [gmst_pkg::PosW-1:0] sz,
                                            input logic signed [gmst_pkg::PosW-1:0] ex,
                                            input logic signed [gmst_pkg::PosW-1:0] ey,
                                            input logic signed [gmst_pkg::PosW-1:0] ez,
                                            input logic [gmst_pkg::ExtrW-1:0] amount,
                                            input logic [gmst_pkg::FeedW-1:0] feed,
                                            input logic ext, input logic kind);
    gmst_pkg::seg_t s;
    s.start_x = sx;
    s.start_y = sy;
    s.start_z = sz;
    s.end_x = ex;
    s.end_y = ey;
    s.end_z = ez;
    s.extrusion_amount = amount;
    s.speed = feed;
    s.extruding = ext;
    s.step_kind = kind;
    return s;
  endfunction

  function automatic void add_row(input row_t r);
    script.insert(script.size(), r);
  endfunction

  function automatic void push_cmd(input gmst_pkg::cmd_t c);
    add_row('{ROW_CMD, c, 1'b0, '0, '0, 1'b0});
  endfunction

  function automatic void push_checked(input gmst_pkg::cmd_t c, input gmst_pkg::seg_t s);
    add_row('{ROW_CMD, c, 1'b1, s, '0, 1'b0});
  endfunction

  function automatic void push_cfg(input logic [gmst_pkg::CfgIdxW-1:0] idx,
                                   input logic value);
    add_row('{ROW_CFG, '0, 1'b0, '0, idx, value});
  endfunction

  // Mostly small moves near the origin, leaning positive if lean_up; extremes and full-range values mixed in.
  function automatic logic signed [gmst_pkg::PosW-1:0] pick_word(input bit lean_up);
    int offset;
    offset = lean_up ? 32'sh0010_0000 : 32'sh0064_0000;
    case ($urandom_range(15))
      0: return POS_MAX;
      1: return POS_MIN;
      2, 3: return $urandom;
      4: return '0;
      default: return int'($urandom_range(32'h00C8_0000)) - offset;
    endcase
  endfunction

  function automatic gmst_pkg::cmd_t random_cmd();
    gmst_pkg::cmd_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) c.func = gmst_pkg::FUNC_LINEAR;
    else if (pick < 75) c.func = gmst_pkg::FUNC_RAPID;
    else if (pick < 93) c.func = gmst_pkg::FUNC_HOME;
    else c.func = FUNC_SPARE;
    c.has_x = ($urandom_range(3) != 0);
    c.has_y = ($urandom_range(3) != 0);
    c.has_z = ($urandom_range(3) != 0);
    c.has_e = ($urandom_range(3) != 0);
    c.has_f = ($urandom_range(1) != 0);
    if (c.func == gmst_pkg::FUNC_HOME && $urandom_range(2) == 0) begin
      {c.has_x, c.has_y, c.has_z} = '0;
    end
    c.x_word = pick_word(!abs_pos_mode);
    c.y_word = pick_word(!abs_pos_mode);
    c.z_word = pick_word(!abs_pos_mode);
    c.e_word = pick_word(!abs_ext_mode);
    case ($urandom_range(7))
      0: c.f_word = '0;
      1: c.f_word = '1;
      default: c.f_word = $urandom;
    endcase
    return c;
  endfunction

  task automatic send_cmd(input gmst_pkg::cmd_t c, input bit typed,
                          input gmst_pkg::seg_t typed_seg);
    gmst_pkg::seg_t predicted;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 30) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {func, has_x, has_y, has_z, has_e, has_f, x_word, y_word, z_word, e_word, f_word} = c;
    do @(posedge clk); while (!in_ready);
    predicted = track_command(c);
    pending_segments.insert(pending_segments.size(), typed ? typed_seg : predicted);
  endtask

  // Stops sending and waits until every expected segment has come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input logic [gmst_pkg::CfgIdxW-1:0] idx, input logic value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == gmst_pkg::CFG_ABS_POSITIONING) abs_pos_mode = value;
    else if (idx == gmst_pkg::CFG_ABS_EXTRUSION) abs_ext_mode = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      fault_count++;
    end
  endtask

  always @(negedge clk) out_ready = !(stalls_on && $urandom_range(99) < 30);

  always @(posedge clk) begin
    gmst_pkg::seg_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_segments.size() == 0) begin
        $display("%0t: segment transfer with nothing expected", $time);
        fault_count++;
      end else begin
        want = pending_segments.pop_front();
        check_field("start_x", want.start_x, start_x);
        check_field("start_y", want.start_y, start_y);
        check_field("start_z", want.start_z, start_z);
        check_field("end_x", want.end_x, end_x);
        check_field("end_y", want.end_y, end_y);
        check_field("end_z", want.end_z, end_z);
        check_field("extrusion_amount", {1'b0, want.extrusion_amount},
                    {1'b0, extrusion_amount});
        check_field("speed", want.speed, speed);
        check_field("extruding", {31'b0, want.extruding}, {31'b0, extruding});
        check_field("step_kind", {31'b0, want.step_kind}, {31'b0, step_kind});
      end
    end
  end

  initial begin
    #2400000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    {func, has_x, has_y, has_z, has_e, has_f, x_word, y_word, z_word, e_word, f_word} = '0;

    // Absolute modes out of reset: feed gating, extremes, extrusion clamp and homing.
    push_checked(mk_cmd(gmst_pkg::FUNC_RAPID, 5'b00001, 0, 0, 0, 0, 32'hFFFF_FFFF),
                 mk_seg(0, 0, 0, 0, 0, 0, '0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    push_checked(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b11110, POS_MAX, POS_MIN, 0, MM,
                        32'h1234_5678),
                 mk_seg(0, 0, 0, POS_MAX, POS_MIN, 0, 31'h0001_0000, 0, 1'b1, 1'b1));
    push_checked(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00011, 0, 0, 0, MM, 32'h0064_0000),
                 mk_seg(POS_MAX, POS_MIN, 0, POS_MAX, POS_MIN, 0, '0, 32'h0064_0000,
                        1'b0, 1'b1));
    push_checked(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00010, 0, 0, 0, POS_MIN, 0),
                 mk_seg(POS_MAX, POS_MIN, 0, POS_MAX, POS_MIN, 0, '0, 0, 1'b0, 1'b1));
    push_checked(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00010, 0, 0, 0, POS_MAX, 0),
                 mk_seg(POS_MAX, POS_MIN, 0, POS_MAX, POS_MIN, 0, EXTR_SAT, 0, 1'b1, 1'b1));
    push_checked(mk_cmd(gmst_pkg::FUNC_HOME, 5'b00011, 32'sh0123_4567, -1, 7, 0,
                        32'hFFFF_FFFF),
                 mk_seg(POS_MAX, POS_MIN, 0, 0, 0, 0, '0, 0, 1'b0, 1'b0));
    push_checked(mk_cmd(gmst_pkg::FUNC_RAPID, 5'b11111, 32'sh0005_0000, 32'shFFFD_0000,
                        POS_MAX, 32'sh0000_0100, 32'h0000_0001),
                 mk_seg(0, 0, 0, 32'sh0005_0000, 32'shFFFD_0000, POS_MAX, '0, 1, 1'b0, 1'b0));
    push_checked(mk_cmd(gmst_pkg::FUNC_HOME, 5'b01000, 0, 0, 0, 0, 0),
                 mk_seg(32'sh0005_0000, 32'shFFFD_0000, POS_MAX, 32'sh0005_0000, 0, POS_MAX,
                        '0, 0, 1'b0, 1'b0));
    push_checked(mk_cmd(gmst_pkg::FUNC_HOME, 5'b10100, 0, 0, 0, 0, 0),
                 mk_seg(32'sh0005_0000, 0, POS_MAX, 0, 0, 0, '0, 0, 1'b0, 1'b0));
    push_checked(mk_cmd(FUNC_SPARE, 5'b10001, POS_MIN, 0, 0, 0, 32'h8000_0000),
                 mk_seg(0, 0, 0, POS_MIN, 0, 0, '0, 32'h8000_0000, 1'b0, 1'b0));
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00001, 0, 0, 0, 0, 32'h0001_0000));
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00010, 0, 0, 0, 32'sh0000_0101, 0));
    // Relative and then mixed modes: sums run into both saturation limits; stray indexes must be ignored.
    push_cfg(gmst_pkg::CFG_ABS_POSITIONING, 1'b0);
    push_cfg(gmst_pkg::CFG_ABS_EXTRUSION, 1'b0);
    push_cfg(CFG_UNUSED_A, 1'b1);
    push_cfg(CFG_UNUSED_B, 1'b1);
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b11110, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 0));
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b11110, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 0));
    push_cmd(mk_cmd(gmst_pkg::FUNC_RAPID, 5'b11110, POS_MIN, POS_MIN, POS_MIN, POS_MIN, 0));
    push_cmd(mk_cmd(gmst_pkg::FUNC_RAPID, 5'b11111, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                    32'h0000_0C80));
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00010, 0, 0, 0, MM, 0));
    push_cfg(gmst_pkg::CFG_ABS_POSITIONING, 1'b1);
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b11011, 32'sh0002_0000, 32'sh0003_0000, 0, MM,
                    32'h0096_0000));
    push_cfg(gmst_pkg::CFG_ABS_EXTRUSION, 1'b1);
    push_cfg(gmst_pkg::CFG_ABS_POSITIONING, 1'b0);
    push_cmd(mk_cmd(gmst_pkg::FUNC_LINEAR, 5'b00110, 0, 0, MM, 32'sh0004_0000, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        drain();
        write_mode(script[i].index, script[i].data);
      end else begin
        send_cmd(script[i].cmd, script[i].typed, script[i].seg);
      end
    end

    // One phase per mode pair; the first runs with no gaps or stalls at all.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      gaps_on = (phase != 0);
      stalls_on = (phase != 0);
      write_mode(gmst_pkg::CFG_ABS_POSITIONING, phase[0]);
      write_mode(gmst_pkg::CFG_ABS_EXTRUSION, phase[1]);
      if (phase >= 2) begin
        write_mode(phase == 2 ? CFG_UNUSED_A : CFG_UNUSED_B, ($urandom_range(1) != 0));
      end
      for (int n = 0; n < 100; n++) begin
        if ((phase == 1 && n == 50) || $urandom_range(99) == 0) drain();
        send_cmd(random_cmd(), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fault_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gmst_pkg.sv
rtl/core/gmst_in_reg.sv
rtl/core/gmst_exec.sv
rtl/core/gmst_out_reg.sv
rtl/core/gcode_motion_step_tracker.sv
bench/testbench.sv
